// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the source text tokenizer: scanner modes,
// token kinds, the emitter states, the per-request plan and character codes.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Sizing.
  localparam int unsigned MAX_TOKEN_LEN_DEF = 32;
  localparam int unsigned RES_LIMIT         = 33;
  localparam int unsigned RES_CMP_W         = 7;
  localparam int unsigned IDX_W             = 5;
  localparam int unsigned LINE_W            = 16;

  localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;
  localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;

  // Input action codes.
  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Scanner modes.
  typedef enum logic [3:0] {
    M_WS    = 4'd0,
    M_IDENT = 4'd1,
    M_INT   = 4'd2,
    M_DBL   = 4'd3,
    M_PDBL  = 4'd4,
    M_STR   = 4'd5,
    M_ESC   = 4'd6,
    M_PCOM  = 4'd7,
    M_COM   = 4'd8
  } mode_t;

  // Token kinds as they appear on the result channel.
  typedef enum logic [2:0] {
    K_IDENT = 3'd0,
    K_INT   = 3'd1,
    K_DBL   = 3'd2,
    K_STR   = 3'd3,
    K_OP    = 3'd4,
    K_ERR   = 3'd5
  } kind_t;

  // Result emitter states.
  typedef enum logic [1:0] {
    E_IDLE,
    E_PRIME,
    E_TOKEN,
    E_EXTRA
  } emit_state_t;

  // What one request does, as decided by the scanner decoder.
  typedef struct packed {
    logic       emit;        // read out the buffered token
    kind_t      emit_kind;
    logic       extra;       // one single-byte result after any token
    kind_t      extra_kind;
    logic       wr_en;       // append a byte to the text buffer
    logic [7:0] wr_byte;
    logic       count_clr;   // token closed or dropped before the append
    mode_t      mode_nxt;
    logic       line_inc;
    logic       halt_set;
    logic       flush;
  } stt_plan_t;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

// ----- rtl/source_text_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Character-at-a-time lexical scanner. Token text is kept in a synchronous
// text buffer memory and read out byte by byte when the token closes.
// ----------------------------------------------------------------------------
// A request is accepted only while the emitter is idle. One that closes no token is done on
// acceptance, apart from a trailing operator or error result. One that closes a token is
// accepted, the emitter primes the text buffer read, then sends one byte a cycle from its
// registered read port while the output register is free, then any trailing result.
// Results leave through an output register. Synchronous active-low reset returns
// to whitespace mode, line 1, empty token; buffer contents are not cleared.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [7:0]          in_char_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_token_kind,
  output logic [LINE_W-1:0]   out_line_number,
  output logic [7:0]          out_text_byte,
  output logic [IDX_W-1:0]    out_byte_index,
  output logic                out_text_empty,
  output logic                out_truncated,
  output logic                out_token_end,
  output logic                out_last
);

  localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_TOKEN_LEN);

  // Scanner state.
  mode_t             mode_r, mode_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              halt_r, halt_nxt;

  // Emitter state.
  emit_state_t       state_r, state_nxt;
  logic [CW-1:0]     em_count_r;
  kind_t             em_kind_r;
  logic              em_trunc_r;
  logic [LINE_W-1:0] em_line_r;
  logic              extra_r;
  kind_t             xkind_r;
  logic [7:0]        xbyte_r;
  logic [CW-1:0]     rd_idx_r;
  logic              pend_wr_r;
  logic [AW-1:0]     pend_addr_r;
  logic [7:0]        pend_byte_r;

  // Text buffer.
  logic [7:0]        text_mem [MAX_TOKEN_LEN];
  logic [7:0]        rdata_r;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;

  // Output register.
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [LINE_W-1:0] out_line_r;
  logic [7:0]        out_byte_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_empty_r;
  logic              out_trunc_r;
  logic              out_end_r;
  logic              out_last_r;

  // Control.
  stt_plan_t         plan;
  logic              acc;
  logic              slot_free;
  logic              load_tok;
  logic              load_extra;
  logic [CW-1:0]     rd_inc;
  logic              tok_empty;
  logic              is_final;
  logic              at_cap;
  logic              tok_done;
  logic              go_extra;
  logic              pend_commit;
  logic [CW-1:0]     base;
  logic              ovf_base;
  logic              room;
  logic              app_ok;

  // Scanner decision for the offered request.
  stt_decode u_decode (
    .mode_i   (mode_r),
    .single_i (count_r == CW'(1)),
    .halted_i (halt_r),
    .action_i (in_action),
    .char_i   (in_char_code),
    .plan_o   (plan)
  );

  assign acc = in_valid && in_ready;

  // Append position and next scanner state.
  always_comb begin
    base     = plan.count_clr ? '0 : count_r;
    ovf_base = plan.count_clr ? 1'b0 : ovf_r;
    room     = (base < CW'(MAX_TOKEN_LEN));
    app_ok   = plan.wr_en && room;

    if (plan.flush) begin
      mode_nxt  = M_WS;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      line_nxt  = LINE_FIRST;
      halt_nxt  = 1'b0;
    end else begin
      mode_nxt  = plan.mode_nxt;
      count_nxt = app_ok ? base + CW'(1) : base;
      ovf_nxt   = (plan.wr_en && !room) ? 1'b1 : ovf_base;
      line_nxt  = (plan.line_inc && line_r != LINE_MAX) ? line_r + LINE_W'(1) : line_r;
      halt_nxt  = halt_r || plan.halt_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_WS;
      count_r <= '0;
      ovf_r   <= 1'b0;
      line_r  <= LINE_FIRST;
      halt_r  <= 1'b0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      line_r  <= line_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // Token read-out indexing and result limit.
  always_comb begin
    rd_inc    = rd_idx_r + CW'(1);
    tok_empty = (em_count_r == '0);
    is_final  = tok_empty || (rd_inc == em_count_r);
    at_cap    = (RES_CMP_W'(rd_idx_r) == RES_CMP_W'(RES_LIMIT - 1));
    tok_done  = is_final || at_cap;
    go_extra  = extra_r && !at_cap;
  end

  // Emitter next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE: begin
        if (acc) begin
          if (plan.emit) begin
            state_nxt = E_PRIME;
          end else if (plan.extra) begin
            state_nxt = E_EXTRA;
          end
        end
      end
      E_PRIME: state_nxt = E_TOKEN;
      E_TOKEN: begin
        if (load_tok && tok_done) begin
          state_nxt = go_extra ? E_EXTRA : E_IDLE;
        end
      end
      E_EXTRA: begin
        if (slot_free) begin
          state_nxt = E_IDLE;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  // Emitter outputs: handshake, loads and buffer port control.
  always_comb begin
    slot_free   = !out_valid_r || out_ready;
    in_ready    = (state_r == E_IDLE);
    load_tok    = (state_r == E_TOKEN) && slot_free;
    load_extra  = (state_r == E_EXTRA) && slot_free;
    raddr       = (load_tok && !tok_done) ? rd_inc[AW-1:0] : rd_idx_r[AW-1:0];
    pend_commit = pend_wr_r && load_tok && tok_done;
    mem_we      = (acc && app_ok && !plan.emit) || pend_commit;
    mem_waddr   = pend_commit ? pend_addr_r : base[AW-1:0];
    mem_wdata   = pend_commit ? pend_byte_r : plan.wr_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= E_IDLE;
      pend_wr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc) begin
        pend_wr_r <= plan.emit && app_ok;
      end else if (pend_commit) begin
        pend_wr_r <= 1'b0;
      end
    end
  end

  // Token description captured with the request; the append waits if the
  // old token must be read out first.
  always_ff @(posedge clk) begin
    if (acc) begin
      em_count_r  <= count_r;
      em_kind_r   <= plan.emit_kind;
      em_trunc_r  <= ovf_r;
      em_line_r   <= line_r;
      extra_r     <= plan.extra;
      xkind_r     <= plan.extra_kind;
      xbyte_r     <= in_char_code;
      pend_addr_r <= base[AW-1:0];
      pend_byte_r <= plan.wr_byte;
      rd_idx_r    <= '0;
    end else if (load_tok && !tok_done) begin
      rd_idx_r <= rd_inc;
    end
  end

  // Text buffer memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= text_mem[raddr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_tok || load_extra) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tok) begin
      out_kind_r  <= em_kind_r;
      out_line_r  <= em_line_r;
      out_byte_r  <= tok_empty ? 8'h00 : rdata_r;
      out_idx_r   <= IDX_W'(rd_idx_r);
      out_empty_r <= tok_empty;
      out_trunc_r <= em_trunc_r;
      out_end_r   <= is_final;
      out_last_r  <= at_cap || (is_final && !extra_r);
    end else if (load_extra) begin
      out_kind_r  <= xkind_r;
      out_line_r  <= em_line_r;
      out_byte_r  <= xbyte_r;
      out_idx_r   <= '0;
      out_empty_r <= 1'b0;
      out_trunc_r <= 1'b0;
      out_end_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_kind_r;
  assign out_line_number = out_line_r;
  assign out_text_byte   = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_text_empty  = out_empty_r;
  assign out_truncated   = out_trunc_r;
  assign out_token_end   = out_end_r;
  assign out_last        = out_last_r;

  // Whitespace mode never holds buffered text.
  a_ws_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_WS) |-> (count_r == '0))
    else $error("whitespace mode with buffered text");

  // After an unknown escape the scanner sits in whitespace mode.
  a_halt_ws: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (mode_r == M_WS))
    else $error("halted scanner not in whitespace mode");

  // Read-out never runs past the captured token length.
  a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_TOKEN && em_count_r != '0) |-> (rd_idx_r < em_count_r))
    else $error("token read index beyond token length");

  // A deferred append is written before the next request is taken.
  a_pend_block: assert property (@(posedge clk) disable iff (!rst_n)
    pend_wr_r |-> !in_ready)
    else $error("request accepted with a buffer write pending");

  // The single trailing result always ends the request.
  a_extra_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load_extra |=> (state_r == E_IDLE))
    else $error("emitter busy after trailing result");

endmodule

// ----- rtl/stt_decode.sv -----
// ----------------------------------------------------------------------------
// stt_decode
// Scanner decoder. From the current mode and one request it decides whether
// the open token closes, whether an operator or error result follows, what
// byte is appended to the text buffer and the next scanner mode.
// ----------------------------------------------------------------------------
module stt_decode import stt_pkg::*; (
  input  mode_t       mode_i,
  input  logic        single_i,   // exactly one byte buffered
  input  logic        halted_i,
  input  logic        action_i,
  input  logic [7:0]  char_i,
  output stt_plan_t   plan_o
);

  // Modes that hold a token which is emitted when it closes.
  function automatic logic closes(input mode_t m);
    logic r;
    case (m)
      M_IDENT, M_INT, M_DBL, M_PDBL, M_STR, M_ESC, M_PCOM: r = 1'b1;
      default:                                              r = 1'b0;
    endcase
    return r;
  endfunction

  // Token kind of an open token. A lone dot is an operator.
  function automatic kind_t kind_of(input mode_t m, input logic single);
    kind_t k;
    case (m)
      M_IDENT:      k = K_IDENT;
      M_INT:        k = K_INT;
      M_DBL:        k = K_DBL;
      M_PDBL:       k = single ? K_OP : K_DBL;
      M_STR, M_ESC: k = K_STR;
      default:      k = K_OP;
    endcase
    return k;
  endfunction

  mode_t      mp;
  mode_t      mode_new;
  logic       pre_end;
  logic       end_req;
  logic       clr_req;
  logic       op_req;
  logic       err_req;
  logic       app_req;
  logic       line_req;
  logic [7:0] app_byte;

  always_comb begin
    mp       = mode_i;
    mode_new = mode_i;
    pre_end  = 1'b0;
    end_req  = 1'b0;
    clr_req  = 1'b0;
    op_req   = 1'b0;
    err_req  = 1'b0;
    app_req  = 1'b0;
    line_req = 1'b0;
    app_byte = char_i;

    if (action_i == ACT_FLUSH) begin
      mode_new = M_WS;
    end else if (!halted_i) begin
      if (mode_i == M_ESC) begin
        // Escape translation; anything unknown halts the scanner.
        case (char_i)
          CH_N: begin
            app_req  = 1'b1;
            app_byte = CH_LF;
            mode_new = M_STR;
          end
          CH_R: begin
            app_req  = 1'b1;
            app_byte = CH_CR;
            mode_new = M_STR;
          end
          CH_T: begin
            app_req  = 1'b1;
            app_byte = CH_TAB;
            mode_new = M_STR;
          end
          CH_BSLASH: begin
            app_req  = 1'b1;
            app_byte = CH_BSLASH;
            mode_new = M_STR;
          end
          default: begin
            err_req  = 1'b1;
            clr_req  = 1'b1;
            mode_new = M_WS;
          end
        endcase
      end else if (mode_i == M_COM) begin
        // A comment runs to the end of the line.
        if (char_i == CH_LF || char_i == CH_CR) begin
          clr_req  = 1'b1;
          line_req = 1'b1;
          mode_new = M_WS;
        end
      end else begin
        // A lone slash closes as an operator and the byte is scanned again.
        if (mode_i == M_PCOM && char_i != CH_SLASH) begin
          pre_end = 1'b1;
          mp      = M_WS;
        end
        mode_new = mp;

        case (char_i) inside
          [CH_0:CH_9]: begin
            if (mp == M_WS) begin
              mode_new = M_INT;
            end else if (mp == M_PDBL) begin
              mode_new = M_DBL;
            end
            app_req = 1'b1;
          end
          CH_DOT: begin
            if (mp == M_WS) begin
              mode_new = M_PDBL;
              app_req  = 1'b1;
            end else if (mp == M_INT) begin
              mode_new = M_DBL;
              app_req  = 1'b1;
            end else if (mp == M_STR) begin
              app_req = 1'b1;
            end else begin
              end_req  = 1'b1;
              op_req   = 1'b1;
              mode_new = M_WS;
            end
          end
          CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
          CH_EQ, CH_MINUS, CH_SEMI, CH_COMMA: begin
            if (mp == M_STR) begin
              app_req = 1'b1;
            end else begin
              end_req  = 1'b1;
              op_req   = 1'b1;
              mode_new = M_WS;
            end
          end
          CH_SPACE, CH_TAB: begin
            if (mp == M_STR) begin
              app_req = 1'b1;
            end else begin
              end_req  = 1'b1;
              mode_new = M_WS;
            end
          end
          CH_LF, CH_CR: begin
            end_req  = 1'b1;
            line_req = 1'b1;
            mode_new = M_WS;
          end
          CH_QUOTE: begin
            end_req  = 1'b1;
            mode_new = (mp == M_STR) ? M_WS : M_STR;
          end
          CH_BSLASH: begin
            if (mp == M_STR) begin
              mode_new = M_ESC;
            end else begin
              end_req  = 1'b1;
              op_req   = 1'b1;
              mode_new = M_WS;
            end
          end
          CH_SLASH: begin
            if (mp == M_STR) begin
              app_req = 1'b1;
            end else if (mp == M_PCOM) begin
              clr_req  = 1'b1;
              mode_new = M_COM;
            end else begin
              end_req  = 1'b1;
              app_req  = 1'b1;
              mode_new = M_PCOM;
            end
          end
          default: begin
            if (mp == M_WS || mp == M_INT || mp == M_DBL) begin
              end_req  = 1'b1;
              mode_new = M_IDENT;
            end
            app_req = 1'b1;
          end
        endcase
      end
    end

    // Assemble the plan.
    if (action_i == ACT_FLUSH) begin
      plan_o.emit = !halted_i && closes(mode_i);
    end else begin
      plan_o.emit = pre_end || (end_req && closes(mp));
    end
    plan_o.emit_kind  = kind_of(mode_i, single_i);
    plan_o.extra      = op_req || err_req;
    plan_o.extra_kind = err_req ? K_ERR : K_OP;
    plan_o.wr_en      = app_req;
    plan_o.wr_byte    = app_byte;
    plan_o.count_clr  = pre_end || end_req || clr_req;
    plan_o.mode_nxt   = mode_new;
    plan_o.line_inc   = line_req;
    plan_o.halt_set   = err_req;
    plan_o.flush      = (action_i == ACT_FLUSH);
  end

endmodule
